>>> rtl/core/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg: first-fit capacity allocator shared definitions
// Sizes of the slot row and max tree, channel payloads, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

	localparam int SLOTS     = 1024;
	localparam int LVLS      = $clog2(SLOTS);
	localparam int LEAF_BASE = 1 << LVLS;
	localparam int NODE_W    = LVLS + 1;
	localparam int AMT_W     = 32;
	localparam int IDX_W     = 10;
	localparam int POS_W     = 11;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_ALLOC = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] slot_index;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [AMT_W-1:0]  wdata;
		logic [NODE_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_DESC,
		ST_LEAF,
		ST_UP,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/first_fit_capacity_allocator_top.sv
// Request: root read, descent level by level, leaf update, fix-up level by
// level, result hand-off; a miss goes from the root read to the hand-off.
// Load: leaf write and fix-up level by level, no result. One item at a time; the tree
// memory's single read and write port sets the per-level pace.
// After reset the tree is swept to zero, one entry per cycle,
// with req_stall high throughout.
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_top: first-fit capacity allocator
// Max tree over a row of slot capacities; requests take the lowest slot that
// covers the demand and return its 1-based position.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_capacity_allocator_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire ffca_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output ffca_pkg::rsp_t      rsp
);
	import ffca_pkg::*;

	mem_req_t         mreq;
	logic [AMT_W-1:0] rdata;
	logic             rsp_free;
	logic             rsp_emit;
	rsp_t             res;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	ffca_tree_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	ffca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rdata     (rdata),
		.mreq      (mreq),
		.rsp_free  (rsp_free),
		.rsp_emit  (rsp_emit),
		.rsp       (res)
	);

	// output register
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= rsp_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_emit) rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/ffca_tree_store.sv
// ----------------------------------------------------------------------------
// ffca_tree_store: max tree storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_tree_store (
	input  wire logic                      clk,
	input  wire ffca_pkg::mem_req_t        mreq,
	output logic [ffca_pkg::AMT_W-1:0]     rdata
);
	import ffca_pkg::*;

	logic [AMT_W-1:0] mem_q [2**NODE_W];
	logic [AMT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
		rdata_q <= mem_q[mreq.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl: allocator sequencer
// Clear sweep, root check, descent, leaf update and path fix-up, one tree
// level per cycle through a single shared comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire ffca_pkg::req_t        req,
	output logic                       req_stall,
	input  wire logic [ffca_pkg::AMT_W-1:0] rdata,
	output ffca_pkg::mem_req_t         mreq,
	input  wire logic                  rsp_free,
	output logic                       rsp_emit,
	output ffca_pkg::rsp_t             rsp
);
	import ffca_pkg::*;

	state_t            state_q, state_d;
	logic [NODE_W-1:0] node_q, node_d;
	logic [NODE_W-1:0] clr_q;
	logic [AMT_W-1:0]  amt_q, amt_d;
	logic [AMT_W-1:0]  cur_q, cur_d;
	logic              alloc_q, alloc_d;
	rsp_t              res_q, res_d;

	logic              accept;
	logic              slot_ok;
	logic [NODE_W-1:0] leaf_addr;
	logic [AMT_W-1:0]  cmp_b;
	logic              ge;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] parent;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_ok   = (32'(req.slot_index) < 32'(SLOTS));
	assign leaf_addr = NODE_W'(32'(LEAF_BASE) + 32'(req.slot_index));

	// shared comparator
	assign cmp_b  = (state_q == ST_UP) ? cur_q : amt_q;
	assign ge     = (rdata >= cmp_b);
	assign child  = ge ? {node_q[NODE_W-2:0], 1'b0} : {node_q[NODE_W-2:0], 1'b1};
	assign parent = {1'b0, node_q[NODE_W-1:1]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_ALLOC) state_d = ST_ROOT;
					else if (slot_ok)             state_d = ST_UP;
				end
			end
			ST_ROOT: state_d = ge ? ST_DESC : ST_RESP;
			ST_DESC: if (child[NODE_W-1]) state_d = ST_LEAF;
			ST_LEAF: state_d = ST_UP;
			ST_UP: begin
				if (parent == NODE_W'(1)) state_d = alloc_q ? ST_RESP : ST_IDLE;
			end
			ST_RESP: if (rsp_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mreq     = '0;
		node_d   = node_q;
		amt_d    = amt_q;
		cur_d    = cur_q;
		alloc_d  = alloc_q;
		res_d    = res_q;
		rsp_emit = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mreq.we    = 1'b1;
				mreq.waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept) begin
					amt_d   = req.amount;
					alloc_d = (req.req_type == REQ_ALLOC);
					if (req.req_type == REQ_ALLOC) begin
						mreq.raddr = NODE_W'(1);
					end else if (slot_ok) begin
						mreq.we    = 1'b1;
						mreq.waddr = leaf_addr;
						mreq.wdata = req.amount;
						mreq.raddr = leaf_addr ^ NODE_W'(1);
						node_d     = leaf_addr;
						cur_d      = req.amount;
					end
				end
			end
			ST_ROOT: begin
				node_d     = NODE_W'(1);
				mreq.raddr = NODE_W'(2);
				res_d      = '0;
			end
			ST_DESC: begin
				node_d     = child;
				mreq.raddr = child[NODE_W-1] ? child : {child[NODE_W-2:0], 1'b0};
			end
			ST_LEAF: begin
				cur_d          = rdata - amt_q;
				mreq.we        = 1'b1;
				mreq.waddr     = node_q;
				mreq.wdata     = rdata - amt_q;
				mreq.raddr     = node_q ^ NODE_W'(1);
				res_d.found    = 1'b1;
				res_d.position = POS_W'(32'(node_q) - 32'(LEAF_BASE) + 32'd1);
			end
			ST_UP: begin
				cur_d      = ge ? rdata : cur_q;
				mreq.we    = 1'b1;
				mreq.waddr = parent;
				mreq.wdata = ge ? rdata : cur_q;
				mreq.raddr = parent ^ NODE_W'(1);
				node_d     = parent;
			end
			ST_RESP: rsp_emit = rsp_free;
			default: ;
		endcase
	end

	assign rsp = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + NODE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		node_q  <= node_d;
		amt_q   <= amt_d;
		cur_q   <= cur_d;
		alloc_q <= alloc_d;
		res_q   <= res_d;
	end

	a_desc_internal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DESC |-> !node_q[NODE_W-1])
		else $error("descent reached a leaf level node");

	a_leaf_then_up: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEAF |=> state_q == ST_UP)
		else $error("leaf update not followed by path fix-up");

	a_up_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UP |-> node_q > NODE_W'(1))
		else $error("fix-up at root or null node");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_emit && !rsp.found |-> rsp.position == '0)
		else $error("miss carries a position");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_emit |-> rsp_free && state_q == ST_RESP)
		else $error("result emitted with output busy");

endmodule

`default_nettype wire

>>> verif/first_fit_capacity_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_top_tb: first-fit allocator regression
// Drives load and request transfers with random gaps and result stalls,
// tracks the slot capacities in a local max tree and checks every result
// (found flag and 1-based position) in order against that tree.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_capacity_allocator_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ffca_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 48;
	localparam int RANDOM_ITEMS = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t work_queue[$];
	rsp_t expected_grants[$];
	bit [AMT_W-1:0] capacity_tree [2*LEAF_BASE];
	int fail_count = 0;
	int idle_cycles = 0;
	int issued = 0;
	int gap_left = 0;
	int taken = 0;
	int hold_left = 0;

	first_fit_capacity_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic req_t make_item(input req_kind_t kind, input int unsigned slot,
			input logic [AMT_W-1:0] amt);
		req_t t;
		t.req_type = kind;
		t.slot_index = IDX_W'(slot);
		t.amount = amt;
		return t;
	endfunction

	function automatic void refresh_path(input int unsigned leaf);
		int unsigned node;
		node = leaf;
		while (node > 1) begin
			node = node >> 1;
			capacity_tree[node] = (capacity_tree[2*node] > capacity_tree[2*node+1]) ?
				capacity_tree[2*node] : capacity_tree[2*node+1];
		end
	endfunction

	function automatic void predict_grant(input req_t t);
		int unsigned node;
		rsp_t grant;
		grant = '0;
		if (t.req_type == REQ_LOAD) begin
			if (int'(t.slot_index) < SLOTS) begin
				node = LEAF_BASE + t.slot_index;
				capacity_tree[node] = t.amount;
				refresh_path(node);
			end
		end else begin
			if (capacity_tree[1] >= t.amount) begin
				node = 1;
				while (node < LEAF_BASE)
					node = (capacity_tree[2*node] >= t.amount) ? 2*node : 2*node + 1;
				capacity_tree[node] = capacity_tree[node] - t.amount;
				refresh_path(node);
				grant.found = 1'b1;
				grant.position = POS_W'(node - LEAF_BASE + 1);
			end
			expected_grants.push_back(grant);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : driver
		bit held;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else begin
			held = req_valid && req_stall;
			if (req_valid && !req_stall)
				predict_grant(req);
			if (!held) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (work_queue.size() > 0) begin
					req <= work_queue.pop_front();
					req_valid <= 1'b1;
					issued <= issued + 1;
					gap_left <= (((issued / 150) % 3) == 1) ? 0 : $urandom_range(0, 12);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		int draw;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			if (expected_grants.size() == 0) begin
				report_mismatch($sformatf("unexpected result found=%0b position=%0d",
					rsp.found, rsp.position));
			end else begin
				want = expected_grants.pop_front();
				if (rsp.found !== want.found)
					report_mismatch($sformatf("found %0b, expected %0b",
						rsp.found, want.found));
				if (rsp.position !== want.position)
					report_mismatch($sformatf("position %0d, expected %0d",
						rsp.position, want.position));
			end
			taken <= taken + 1;
			draw = (((taken / 40) % 3) == 2) ? 0 : $urandom_range(0, 12);
			hold_left <= draw;
			rsp_stall <= (draw != 0);
		end else if (rsp_valid && hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= (hold_left > 1);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int pick;
		int unsigned slot;
		logic [AMT_W-1:0] amt;

		// empty tree: zero demand, small miss, full-scale miss
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'd0));
		work_queue.push_back(make_item(REQ_ALLOC, 1023, 32'd1));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'hFFFF_FFFF));
		// row ends and full-scale capacity
		work_queue.push_back(make_item(REQ_LOAD, 1023, 32'hFFFF_FFFF));
		work_queue.push_back(make_item(REQ_LOAD, 0, 32'd5));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'hFFFF_FFFF));
		work_queue.push_back(make_item(REQ_ALLOC, 1023, 32'd5));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'd1));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'd0));
		// alternating bit patterns in index and amount
		work_queue.push_back(make_item(REQ_LOAD, 10'h155, 32'hAAAA_AAAA));
		work_queue.push_back(make_item(REQ_LOAD, 10'h2AA, 32'h5555_5555));
		work_queue.push_back(make_item(REQ_LOAD, 512, 32'd100));
		work_queue.push_back(make_item(REQ_LOAD, 511, 32'd50));
		work_queue.push_back(make_item(REQ_ALLOC, 10'h2AA, 32'd60));
		work_queue.push_back(make_item(REQ_ALLOC, 10'h155, 32'd50));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'h5555_5555));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'h8000_0000));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'hAAAA_AAAA));
		// overwrite a loaded slot with zero, exact-fit demand
		work_queue.push_back(make_item(REQ_LOAD, 10'h155, 32'd0));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'd100));
		work_queue.push_back(make_item(REQ_ALLOC, 0, 32'd100));

		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			slot = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
			if (pick < 40) begin
				amt = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1000);
				work_queue.push_back(make_item(REQ_LOAD, slot, amt));
			end else if (pick < 42) begin
				work_queue.push_back(make_item(REQ_LOAD, slot, 32'hFFFF_FFFF));
			end else begin
				case ($urandom_range(0, 9))
					0: amt = '0;
					1, 2: amt = $urandom;
					default: amt = $urandom_range(1, 600);
				endcase
				work_queue.push_back(make_item(REQ_ALLOC, $urandom_range(0, 1023), amt));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (work_queue.size() != 0 || req_valid) @(posedge clk);
		while (expected_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_grants.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
